// ===== design/qsed_pkg.sv =====
// qsed_pkg: shared types, result kind codes and escape tables for the
// quoted string escape decoder. No dependencies; used by the top level
// and by its checker.
package qsed_pkg;

    // one input transaction: a character or the end-of-buffer mark
    typedef struct packed {
        logic [7:0] ch;
        logic       at_end;
    } item_t;

    // one result transaction: decoded byte and its kind code
    typedef struct packed {
        logic [7:0] out_byte;
        logic [2:0] kind;
    } result_t;

    // result kind codes
    localparam logic [2:0] KIND_DATA     = 3'd0;
    localparam logic [2:0] KIND_CLOSED   = 3'd1;
    localparam logic [2:0] KIND_BAD      = 3'd2;
    localparam logic [2:0] KIND_UNTERM   = 3'd3;
    localparam logic [2:0] KIND_NO_QUOTE = 3'd4;

    // characters with a meaning to the scanner
    localparam logic [7:0] CH_DQUOTE    = 8'h22;
    localparam logic [7:0] CH_SQUOTE    = 8'h27;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_DASH      = 8'h2D;
    localparam logic [7:0] CH_LOWER_C   = 8'h63;
    localparam logic [7:0] CH_UPPER_C   = 8'h43;
    localparam logic [7:0] CH_UPPER_M   = 8'h4D;
    localparam logic [7:0] CH_LOWER_A   = 8'h61;
    localparam logic [7:0] CH_LOWER_Z   = 8'h7A;
    localparam logic [7:0] CH_AT        = 8'h40;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] META_BIT     = 8'h80;

    // single-letter escapes: returns {hit, control code}
    function automatic logic [8:0] esc_lookup(input logic [7:0] c);
        logic [8:0] r;
        case (c)
            8'h61:   r = {1'b1, 8'h07};   // a
            8'h62:   r = {1'b1, 8'h08};   // b
            8'h74:   r = {1'b1, 8'h09};   // t
            8'h6E:   r = {1'b1, 8'h0A};   // n
            8'h76:   r = {1'b1, 8'h0B};   // v
            8'h66:   r = {1'b1, 8'h0C};   // f
            8'h72:   r = {1'b1, 8'h0D};   // r
            8'h65:   r = {1'b1, 8'h1B};   // e
            8'h73:   r = {1'b1, 8'h20};   // s
            default: r = 9'd0;
        endcase
        return r;
    endfunction

    // octal digit test
    function automatic logic is_octal(input logic [7:0] c);
        return c[7:3] == 5'b00110;
    endfunction

    // control letter test: upper-cased character lies in '@'..'_'
    function automatic logic is_ctl(input logic [7:0] c);
        return (c >= CH_AT && c <= CH_UNDERSCORE) || (c >= CH_LOWER_A && c <= CH_LOWER_Z);
    endfunction

endpackage

// ===== design/quoted_string_escape_decoder_top.sv =====
// Quoted string escape decoder, top level: input register, scanner state
// machine and result register. Depends on qsed_pkg.
//
// An accepted input transaction is held in the input register; its result, if any,
// moves on to the result register when that register is free or its result is leaving.
// Throughput: one character per cycle while the output is not stalled; the input
// register lets one more transaction in while a finished result waits at a stalled output.
// Reset: rst_n clears valid flags and returns the scanner to idle.
module quoted_string_escape_decoder_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_stall,
    input  qsed_pkg::item_t    item,
    output logic               result_valid,
    input  logic               result_stall,
    output qsed_pkg::result_t  result
);

    typedef enum logic [3:0] {
        ST_IDLE      = 4'd0,
        ST_NORMAL    = 4'd1,
        ST_ESC       = 4'd2,
        ST_OCT1      = 4'd3,
        ST_OCT2      = 4'd4,
        ST_SMALLC    = 4'd5,
        ST_BIGC      = 4'd6,
        ST_BIGC_DASH = 4'd7,
        ST_BIGM      = 4'd8,
        ST_BIGM_DASH = 4'd9,
        ST_M_ESC     = 4'd10,
        ST_M_ESC_C   = 4'd11,
        ST_M_ESC_C_D = 4'd12
    } scan_state_t;

    logic              s1_valid_reg;
    qsed_pkg::item_t   s1_item_reg;
    logic              res_valid_reg;
    qsed_pkg::result_t res_reg;
    scan_state_t       state_reg;
    scan_state_t       state_next;
    logic              quote_dbl_reg;
    logic              quote_dbl_next;
    logic [8:0]        octal_reg;
    logic [8:0]        octal_next;

    logic              has_res;
    qsed_pkg::result_t res_next;
    logic              s1_adv;
    logic              accept;
    logic [7:0]        c;
    logic [7:0]        delim;
    logic [8:0]        esc_hit;
    logic [8:0]        octal_shift;

    // handshake: stage 1 moves on when the result register is free
    assign s1_adv     = s1_valid_reg && (!res_valid_reg || !result_stall);
    assign item_stall = s1_valid_reg && res_valid_reg && result_stall;
    assign accept     = item_valid && !item_stall;

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

    assign c           = s1_item_reg.ch;
    assign delim       = quote_dbl_reg ? qsed_pkg::CH_DQUOTE : qsed_pkg::CH_SQUOTE;
    assign esc_hit     = qsed_pkg::esc_lookup(c);
    assign octal_shift = {octal_reg[5:0], c[2:0]};

    // scanner: next state and optional result for the character in stage 1
    always_comb
    begin
        state_next     = state_reg;
        quote_dbl_next = quote_dbl_reg;
        octal_next     = octal_reg;
        has_res        = 1'b0;
        res_next       = '{out_byte: 8'd0, kind: qsed_pkg::KIND_DATA};

        if (state_reg == ST_IDLE)
        begin
            if (!s1_item_reg.at_end &&
                (c == qsed_pkg::CH_DQUOTE || c == qsed_pkg::CH_SQUOTE))
            begin
                quote_dbl_next = (c == qsed_pkg::CH_DQUOTE);
                state_next     = ST_NORMAL;
            end
            else
            begin
                has_res       = 1'b1;
                res_next.kind = qsed_pkg::KIND_NO_QUOTE;
            end
        end
        else if (s1_item_reg.at_end)
        begin
            has_res       = 1'b1;
            res_next.kind = qsed_pkg::KIND_UNTERM;
            state_next    = ST_IDLE;
        end
        else
        begin
            // data results leave the scanner in normal text, closing and bad escapes go idle
            case (state_reg)
                ST_NORMAL:
                begin
                    if (c == delim)
                    begin
                        has_res       = 1'b1;
                        res_next.kind = qsed_pkg::KIND_CLOSED;
                        state_next    = ST_IDLE;
                    end
                    else if (c == qsed_pkg::CH_BACKSLASH)
                    begin
                        state_next = ST_ESC;
                    end
                    else
                    begin
                        has_res           = 1'b1;
                        res_next.out_byte = c;
                    end
                end
                ST_ESC:
                begin
                    state_next = ST_NORMAL;
                    if (c == delim || c == 8'd0)
                    begin
                        has_res           = 1'b1;
                        res_next.out_byte = c;
                    end
                    else if (esc_hit[8])
                    begin
                        has_res           = 1'b1;
                        res_next.out_byte = esc_hit[7:0];
                    end
                    else if (qsed_pkg::is_octal(c))
                    begin
                        octal_next = {6'd0, c[2:0]};
                        state_next = ST_OCT1;
                    end
                    else if (c == qsed_pkg::CH_LOWER_C)
                    begin
                        state_next = ST_SMALLC;
                    end
                    else if (c == qsed_pkg::CH_UPPER_C)
                    begin
                        state_next = ST_BIGC;
                    end
                    else if (c == qsed_pkg::CH_UPPER_M)
                    begin
                        state_next = ST_BIGM;
                    end
                    else
                    begin
                        has_res       = 1'b1;
                        res_next.kind = qsed_pkg::KIND_BAD;
                        state_next    = ST_IDLE;
                    end
                end
                ST_OCT1, ST_OCT2:
                begin
                    if (!qsed_pkg::is_octal(c))
                    begin
                        has_res       = 1'b1;
                        res_next.kind = qsed_pkg::KIND_BAD;
                        state_next    = ST_IDLE;
                    end
                    else
                    begin
                        octal_next = octal_shift;
                        if (state_reg == ST_OCT1)
                        begin
                            state_next = ST_OCT2;
                        end
                        else
                        begin
                            has_res           = 1'b1;
                            res_next.out_byte = octal_shift[7:0];
                            state_next        = ST_NORMAL;
                        end
                    end
                end
                ST_SMALLC, ST_BIGC_DASH, ST_M_ESC_C_D:
                begin
                    has_res = 1'b1;
                    if (!qsed_pkg::is_ctl(c))
                    begin
                        res_next.kind = qsed_pkg::KIND_BAD;
                        state_next    = ST_IDLE;
                    end
                    else
                    begin
                        // upper-casing and subtracting '@' leave the low five bits
                        res_next.out_byte = {(state_reg == ST_M_ESC_C_D), 2'b00, c[4:0]};
                        state_next        = ST_NORMAL;
                    end
                end
                ST_BIGC, ST_BIGM, ST_M_ESC_C:
                begin
                    if (c != qsed_pkg::CH_DASH)
                    begin
                        has_res       = 1'b1;
                        res_next.kind = qsed_pkg::KIND_BAD;
                        state_next    = ST_IDLE;
                    end
                    else if (state_reg == ST_BIGC)
                    begin
                        state_next = ST_BIGC_DASH;
                    end
                    else if (state_reg == ST_BIGM)
                    begin
                        state_next = ST_BIGM_DASH;
                    end
                    else
                    begin
                        state_next = ST_M_ESC_C_D;
                    end
                end
                ST_BIGM_DASH:
                begin
                    if (c == qsed_pkg::CH_BACKSLASH)
                    begin
                        state_next = ST_M_ESC;
                    end
                    else
                    begin
                        has_res           = 1'b1;
                        res_next.out_byte = c | qsed_pkg::META_BIT;
                        state_next        = ST_NORMAL;
                    end
                end
                ST_M_ESC:
                begin
                    if (c != qsed_pkg::CH_UPPER_C)
                    begin
                        has_res       = 1'b1;
                        res_next.kind = qsed_pkg::KIND_BAD;
                        state_next    = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_M_ESC_C;
                    end
                end
                default:
                begin
                    has_res       = 1'b1;
                    res_next.kind = qsed_pkg::KIND_BAD;
                    state_next    = ST_IDLE;
                end
            endcase
        end
    end

    // control registers: valids and scanner state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            state_reg     <= ST_IDLE;
            quote_dbl_reg <= 1'b0;
            octal_reg     <= 9'd0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_adv)
            begin
                res_valid_reg <= has_res;
                state_reg     <= state_next;
                quote_dbl_reg <= quote_dbl_next;
                octal_reg     <= octal_next;
            end
            else if (res_valid_reg && !result_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_item_reg <= item;
        end
        if (s1_adv && has_res)
        begin
            res_reg <= res_next;
        end
    end

endmodule

// ===== design/qsed_checker.sv =====
// qsed_checker: port-level assertions for the quoted string escape decoder,
// bound to the top level below. Depends on qsed_pkg.
module qsed_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              item_valid,
    input logic              item_stall,
    input qsed_pkg::item_t   item,
    input logic              result_valid,
    input logic              result_stall,
    input qsed_pkg::result_t result
);

    // a stalled result transaction holds
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
    else $error("result changed while stalled");

    // input is held back only by a stalled, waiting result
    assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> result_valid && result_stall)
    else $error("input stalled without output backpressure");

    // kind stays within the defined codes
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result.kind <= qsed_pkg::KIND_NO_QUOTE)
    else $error("undefined result kind");

    // only data transactions carry a byte
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.kind != qsed_pkg::KIND_DATA |-> result.out_byte == 8'd0)
    else $error("non-data result with nonzero byte");

    // a stalled input transaction holds
    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_stall |=> item_valid && $stable(item))
    else $error("input changed while stalled");

endmodule

bind quoted_string_escape_decoder_top qsed_checker u_qsed_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);
